### rtl/ghu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghu_pkg
// Shared widths and constants of the GRU hidden-unit update pipeline.
// ----------------------------------------------------------------------------
package ghu_pkg;

  localparam int unsigned X_W       = 27;  // exponent argument, Q.16 signed
  localparam int unsigned MAG_W     = 63;  // exponential magnitude, Q.32
  localparam int unsigned NUM_W     = 64;  // divider operands, Q.32
  localparam int unsigned Q_W       = 17;  // gate quotient, Q.16 in [0, 1]
  localparam int unsigned DIV_STEPS = 16;  // quotient bits after the first

  localparam logic [NUM_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;

endpackage
`default_nettype wire

### rtl/ghu_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghu_exp
// Pipelined exponential: (1 + x / 2^SQUARINGS) squared SQUARINGS times, two
// stages per squaring, with a saturation mark on overflow.
// ----------------------------------------------------------------------------
module ghu_exp #(
  parameter int unsigned SQUARINGS = 10,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [ghu_pkg::X_W-1:0]    x_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [ghu_pkg::MAG_W-1:0]         mag_o,
  output logic                              sat_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned SHIFT = 16 - SQUARINGS;

  logic signed [40:0] t_d;
  logic [40:0]        t_mag_d;

  logic                      sv_q   [0:SQUARINGS];
  logic [ghu_pkg::MAG_W-1:0] sm_q   [0:SQUARINGS];
  logic                      ss_q   [0:SQUARINGS];
  logic [SIDE_W-1:0]         sd_q   [0:SQUARINGS];

  logic                      av_q   [0:SQUARINGS-1];
  logic [47:0]               p11_q  [0:SQUARINGS-1];
  logic [47:0]               p01_q  [0:SQUARINGS-1];
  logic [47:0]               p00_q  [0:SQUARINGS-1];
  logic [ghu_pkg::MAG_W-1:0] am_q   [0:SQUARINGS-1];
  logic                      as_q   [0:SQUARINGS-1];
  logic                      ab_q   [0:SQUARINGS-1];
  logic [SIDE_W-1:0]         ad_q   [0:SQUARINGS-1];

  always_comb begin
    t_d     = 41'sh1_0000_0000 + (41'(x_i) <<< SHIFT);
    t_mag_d = t_d[40] ? 41'(-t_d) : 41'(t_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm_q[0] <= ghu_pkg::MAG_W'(t_mag_d);
      ss_q[0] <= 1'b0;
      sd_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < SQUARINGS; i++) begin : g_sq
    logic [95:0] sq_d;
    logic        sat_d;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[i]   <= 1'b0;
        sv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        av_q[i]   <= sv_q[i];
        sv_q[i+1] <= av_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p11_q[i] <= sm_q[i][47:24] * sm_q[i][47:24];
        p01_q[i] <= sm_q[i][23:0] * sm_q[i][47:24];
        p00_q[i] <= sm_q[i][23:0] * sm_q[i][23:0];
        am_q[i]  <= sm_q[i];
        as_q[i]  <= ss_q[i];
        ab_q[i]  <= |sm_q[i][62:48];
        ad_q[i]  <= sd_q[i];
      end
    end

    always_comb begin
      sq_d  = {p11_q[i], 48'b0} + {23'b0, p01_q[i], 25'b0} + {48'b0, p00_q[i]};
      sat_d = as_q[i] | ab_q[i] | sq_d[95];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sm_q[i+1] <= sat_d ? am_q[i] : sq_d[94:32];
        ss_q[i+1] <= sat_d;
        sd_q[i+1] <= ad_q[i];
      end
    end
  end

  assign valid_o = sv_q[SQUARINGS];
  assign mag_o   = sm_q[SQUARINGS];
  assign sat_o   = ss_q[SQUARINGS];
  assign side_o  = sd_q[SQUARINGS];

endmodule
`default_nettype wire

### rtl/ghu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghu_div
// Pipelined restoring divider: floor(num * 2^16 / den) for num <= den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module ghu_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ghu_pkg::NUM_W-1:0]     num_i,
  input  logic [ghu_pkg::NUM_W-1:0]     den_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [ghu_pkg::Q_W-1:0]       q_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned N = ghu_pkg::DIV_STEPS;

  logic                      v_q   [0:N];
  logic [ghu_pkg::NUM_W-1:0] rem_q [0:N];
  logic [ghu_pkg::NUM_W-1:0] den_q [0:N];
  logic [ghu_pkg::Q_W-1:0]   q_q   [0:N];
  logic [SIDE_W-1:0]         sd_q  [0:N];

  logic ge0_d;
  assign ge0_d = num_i >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ge0_d ? num_i - den_i : num_i;
      den_q[0] <= den_i;
      q_q[0]   <= {{(ghu_pkg::Q_W-1){1'b0}}, ge0_d};
      sd_q[0]  <= side_i;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [ghu_pkg::NUM_W:0] r2_d;
    logic [ghu_pkg::NUM_W:0] diff_d;
    logic                    ge_d;

    always_comb begin
      r2_d   = {rem_q[j], 1'b0};
      diff_d = r2_d - {1'b0, den_q[j]};
      ge_d   = r2_d >= {1'b0, den_q[j]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge_d ? diff_d[ghu_pkg::NUM_W-1:0] : r2_d[ghu_pkg::NUM_W-1:0];
        den_q[j+1] <= den_q[j];
        q_q[j+1]   <= {q_q[j][ghu_pkg::Q_W-2:0], ge_d};
        sd_q[j+1]  <= sd_q[j];
      end
    end
  end

  assign valid_o = v_q[N];
  assign q_o     = q_q[N];
  assign side_o  = sd_q[N];

endmodule
`default_nettype wire

### rtl/gru_hidden_update_core.sv
// Throughput: one item per cycle unless the output stalls; the depth is set by
// two exponential chains of two stages per squaring and two 17-stage dividers,
// in series.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gru_hidden_update_core
// Fixed-point GRU hidden-unit update: sigmoid reset and update gates, tanh
// candidate, next = n + z * (h - n), saturated to Q8.16.
// ----------------------------------------------------------------------------
module gru_hidden_update_core #(
  parameter int unsigned EXP_SQUARINGS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] reset_from_input_i,
  input  logic signed [23:0] update_from_input_i,
  input  logic signed [23:0] cand_from_input_i,
  input  logic signed [23:0] reset_from_hidden_i,
  input  logic signed [23:0] update_from_hidden_i,
  input  logic signed [23:0] cand_from_hidden_i,
  input  logic signed [23:0] prev_hidden_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] next_hidden_o
);

  typedef enum logic [2:0] {
    TC_POS, TC_NEG, TC_ONE, TC_MONE, TC_ZERO
  } tanh_code_e;

  typedef struct packed {
    logic [23:0] ci;
    logic [23:0] ch;
  } cand_t;

  typedef struct packed {
    cand_t cand;
    logic  sat;
  } r_side_t;

  typedef struct packed {
    logic [23:0] h;
    logic        sat;
  } z_side_t;

  typedef struct packed {
    logic [ghu_pkg::Q_W-1:0] z;
    logic [23:0]             h;
    tanh_code_e              code;
  } t_side_t;

  logic adv;
  logic out_valid_q;

  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  // input stage
  logic               vi_q;
  logic signed [24:0] sum_r_q, sum_z_q;
  cand_t              cand_q;
  logic [23:0]        h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= 1'b0;
    end else if (adv) begin
      vi_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_r_q <= 25'(reset_from_input_i) + 25'(reset_from_hidden_i);
      sum_z_q <= 25'(update_from_input_i) + 25'(update_from_hidden_i);
      cand_q  <= '{ci: cand_from_input_i, ch: cand_from_hidden_i};
      h_q     <= prev_hidden_i;
    end
  end

  // sigmoid gates
  logic                      er_v, ez_v, er_s, ez_s;
  logic [ghu_pkg::MAG_W-1:0] er_m, ez_m;
  cand_t                     er_side;
  logic [23:0]               ez_side;

  ghu_exp #(.SQUARINGS(EXP_SQUARINGS), .SIDE_W($bits(cand_t))) u_exp_r (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vi_q),
    .x_i(-(ghu_pkg::X_W'(sum_r_q))), .side_i(cand_q),
    .valid_o(er_v), .mag_o(er_m), .sat_o(er_s), .side_o(er_side)
  );

  ghu_exp #(.SQUARINGS(EXP_SQUARINGS), .SIDE_W(24)) u_exp_z (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vi_q),
    .x_i(-(ghu_pkg::X_W'(sum_z_q))), .side_i(h_q),
    .valid_o(ez_v), .mag_o(ez_m), .sat_o(ez_s), .side_o(ez_side)
  );

  logic                    dr_v, dz_v;
  logic [ghu_pkg::Q_W-1:0] dr_q, dz_q;
  r_side_t                 dr_side;
  z_side_t                 dz_side;

  ghu_div #(.SIDE_W($bits(r_side_t))) u_div_r (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(er_v),
    .num_i(ghu_pkg::ONE_Q32), .den_i(ghu_pkg::ONE_Q32 + ghu_pkg::NUM_W'(er_m)),
    .side_i(r_side_t'{cand: er_side, sat: er_s}),
    .valid_o(dr_v), .q_o(dr_q), .side_o(dr_side)
  );

  ghu_div #(.SIDE_W($bits(z_side_t))) u_div_z (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(ez_v),
    .num_i(ghu_pkg::ONE_Q32), .den_i(ghu_pkg::ONE_Q32 + ghu_pkg::NUM_W'(ez_m)),
    .side_i(z_side_t'{h: ez_side, sat: ez_s}),
    .valid_o(dz_v), .q_o(dz_q), .side_o(dz_side)
  );

  // r * cand_from_hidden
  logic                    vm_q;
  logic signed [41:0]      rch_q;
  logic [23:0]             ci_m_q, h_m_q;
  logic [ghu_pkg::Q_W-1:0] z_m_q;
  logic [ghu_pkg::Q_W-1:0] r_gate_d;

  assign r_gate_d = dr_side.sat ? '0 : dr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (adv) begin
      vm_q <= dr_v & dz_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rch_q  <= $signed({1'b0, r_gate_d}) * $signed(dr_side.cand.ch);
      ci_m_q <= dr_side.cand.ci;
      h_m_q  <= dz_side.h;
      z_m_q  <= dz_side.sat ? '0 : dz_q;
    end
  end

  // candidate argument
  logic                    va_q;
  logic signed [25:0]      a_q;
  logic [ghu_pkg::Q_W-1:0] z_a_q;
  logic [23:0]             h_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= 26'($signed(ci_m_q)) + 26'(rch_q >>> 16);
      z_a_q <= z_m_q;
      h_a_q <= h_m_q;
    end
  end

  // tanh
  logic                      ep_v, en_v, ep_s, en_s;
  logic [ghu_pkg::MAG_W-1:0] ep_m, en_m;
  logic [ghu_pkg::Q_W-1:0]   ep_side;
  logic [23:0]               en_side;

  ghu_exp #(.SQUARINGS(EXP_SQUARINGS), .SIDE_W(ghu_pkg::Q_W)) u_exp_p (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(va_q),
    .x_i(ghu_pkg::X_W'(a_q)), .side_i(z_a_q),
    .valid_o(ep_v), .mag_o(ep_m), .sat_o(ep_s), .side_o(ep_side)
  );

  ghu_exp #(.SQUARINGS(EXP_SQUARINGS), .SIDE_W(24)) u_exp_n (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(va_q),
    .x_i(-(ghu_pkg::X_W'(a_q))), .side_i(h_a_q),
    .valid_o(en_v), .mag_o(en_m), .sat_o(en_s), .side_o(en_side)
  );

  logic                      vp_q;
  logic [ghu_pkg::NUM_W-1:0] num_q, den_q;
  t_side_t                   tp_q;
  logic [ghu_pkg::NUM_W-1:0] den_d;
  logic                      pge_d;
  tanh_code_e                code_d;

  always_comb begin
    den_d = ghu_pkg::NUM_W'(ep_m) + ghu_pkg::NUM_W'(en_m);
    pge_d = ep_m >= en_m;
    priority if (ep_s && en_s) code_d = TC_ZERO;
    else if (ep_s)            code_d = TC_ONE;
    else if (en_s)            code_d = TC_MONE;
    else if (den_d == '0)     code_d = TC_ZERO;
    else if (pge_d)           code_d = TC_POS;
    else                      code_d = TC_NEG;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= ep_v & en_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= pge_d ? ghu_pkg::NUM_W'(ep_m - en_m) : ghu_pkg::NUM_W'(en_m - ep_m);
      den_q <= den_d;
      tp_q  <= '{z: ep_side, h: en_side, code: code_d};
    end
  end

  logic                    dt_v;
  logic [ghu_pkg::Q_W-1:0] dt_q;
  t_side_t                 dt_side;

  ghu_div #(.SIDE_W($bits(t_side_t))) u_div_t (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vp_q),
    .num_i(num_q), .den_i(den_q), .side_i(tp_q),
    .valid_o(dt_v), .q_o(dt_q), .side_o(dt_side)
  );

  // candidate gate value
  logic                    vn_q;
  logic signed [17:0]      n_q;
  logic [ghu_pkg::Q_W-1:0] z_n_q;
  logic [23:0]             h_n_q;
  logic signed [17:0]      n_d;

  always_comb begin
    unique case (dt_side.code)
      TC_POS:  n_d = $signed({1'b0, dt_q});
      TC_NEG:  n_d = -$signed({1'b0, dt_q});
      TC_ONE:  n_d = 18'sd65536;
      TC_MONE: n_d = -18'sd65536;
      TC_ZERO: n_d = '0;
      default: n_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (adv) begin
      vn_q <= dt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q   <= n_d;
      z_n_q <= dt_side.z;
      h_n_q <= dt_side.h;
    end
  end

  // z * (h - n)
  logic               vz_q;
  logic signed [42:0] zp_q;
  logic signed [17:0] n_z_q;
  logic signed [24:0] diff_d;

  assign diff_d = 25'($signed(h_n_q)) - 25'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vz_q <= 1'b0;
    end else if (adv) begin
      vz_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zp_q  <= $signed({1'b0, z_n_q}) * diff_d;
      n_z_q <= n_q;
    end
  end

  // output register
  logic signed [27:0] y_d;
  logic signed [23:0] y_sat_d;
  logic signed [23:0] y_q;

  always_comb begin
    y_d = 28'(n_z_q) + 28'(zp_q >>> 16);
    priority if (y_d > 28'sd8388607) y_sat_d = 24'sh7F_FFFF;
    else if (y_d < -28'sd8388608)    y_sat_d = 24'sh80_0000;
    else                             y_sat_d = y_d[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q <= y_sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_hidden_o = y_q;

endmodule
`default_nettype wire
